// ===== src/motor_move_supervisor_macros.svh =====
// Assertion macros shared by the motor move supervisor RTL.
`ifndef MOTOR_MOVE_SUPERVISOR_MACROS_SVH
`define MOTOR_MOVE_SUPERVISOR_MACROS_SVH
`ifndef SYNTHESIS
`define MMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("motor move supervisor: same-cycle check failed");
`define MMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("motor move supervisor: next-cycle check failed");
`else
`define MMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/mms_pkg.sv =====
// Types and constants shared by the motor move supervisor modules.
package mms_pkg;

  localparam int unsigned RegAddrW = 4;
  localparam int unsigned RegDataW = 32;

  localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] REG_BACKUP_CAP  = 2'd1;
  localparam logic [1:0] REG_DWELL       = 2'd2;

  localparam logic [9:0]  TICK_PERIOD_RST = 10'd20;
  localparam logic [15:0] BACKUP_CAP_RST  = 16'd500;
  localparam logic [15:0] DWELL_RST       = 16'd500;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_PUSH   = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RUN     = 3'd1;
  localparam logic [2:0] ST_OK      = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_NOITEM  = 3'd4;
  localparam logic [2:0] ST_STALL   = 3'd5;

  typedef struct packed {
    logic        action;
    logic [1:0]  mode;
    logic        direction;
    logic [19:0] timeout_ms;
    logic [7:0]  stall_limit;
    logic        end_switch;
    logic        front_switch;
    logic        back_switch;
    logic        stall_sense;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       motor_on;
    logic       motor_reverse;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  tick_period_ms;
    logic [15:0] backup_cap_ms;
    logic [15:0] dwell_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [2:0]  phase;
    logic [19:0] elapsed_ms;
    logic [7:0]  stall_run;
    logic [15:0] dwell_left_ms;
    logic [19:0] time_limit;
    logic [7:0]  stall_threshold;
    logic        drive_reverse;
  } state_t;

endpackage

// ===== src/mms_cfg_regs.sv =====
// APB-style configuration registers of the motor move supervisor.
module mms_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mms_pkg::RegAddrW-1:0]    paddr,
  input  logic [mms_pkg::RegDataW-1:0]    pwdata,
  output logic [mms_pkg::RegDataW-1:0]    prdata,
  output logic                            pready,
  output mms_pkg::cfg_t                   cfg_o
);

  mms_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_ms <= mms_pkg::TICK_PERIOD_RST;
      cfg_q.backup_cap_ms  <= mms_pkg::BACKUP_CAP_RST;
      cfg_q.dwell_ms       <= mms_pkg::DWELL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        mms_pkg::REG_TICK_PERIOD: cfg_q.tick_period_ms <= pwdata[9:0];
        mms_pkg::REG_BACKUP_CAP:  cfg_q.backup_cap_ms  <= pwdata[15:0];
        mms_pkg::REG_DWELL:       cfg_q.dwell_ms       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mms_pkg::REG_TICK_PERIOD: prdata = {22'd0, cfg_q.tick_period_ms};
      mms_pkg::REG_BACKUP_CAP:  prdata = {16'd0, cfg_q.backup_cap_ms};
      mms_pkg::REG_DWELL:       prdata = {16'd0, cfg_q.dwell_ms};
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== src/mms_step.sv =====
// Next-state and result logic for one start or tick beat.
module mms_step (
  input  mms_pkg::cfg_t      cfg_i,
  input  mms_pkg::state_t    state_i,
  input  mms_pkg::in_item_t  item_i,
  output mms_pkg::state_t    state_o,
  output mms_pkg::out_item_t result_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RUN1   = 3'd1;
  localparam logic [2:0] PH_RUN2   = 3'd2;
  localparam logic [2:0] PH_LAST   = 3'd4;
  localparam logic [2:0] PH_DWELL  = 3'd4;
  localparam logic [2:0] PH_DWELL1 = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] status;
    logic       load_dwell;
    logic       clr_stall;
  } leave_t;

  // Odd toggle phases hold while the switch is high, even ones while it is low.
  function automatic logic exits(logic [2:0] k, logic sw);
    return k[0] ? !sw : sw;
  endfunction

  // Walks forward from toggle phase k, passing over phases whose exit level
  // is already present and stopping at a dwell when one is due.
  function automatic leave_t toggle_leave(logic [2:0] k, logic sw, logic dw,
                                          logic dwell_nz);
    leave_t     r;
    logic [2:0] kv;
    logic       dv;
    logic       done;
    r.phase      = k;
    r.status     = mms_pkg::ST_RUN;
    r.load_dwell = 1'b0;
    r.clr_stall  = 1'b0;
    kv           = k;
    dv           = dw;
    done         = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done) begin
        if (dv && (kv <= PH_RUN2) && dwell_nz) begin
          r.phase      = kv + PH_DWELL;
          r.load_dwell = 1'b1;
          done         = 1'b1;
        end else begin
          dv = 1'b1;
          kv = kv + 3'd1;
          if (kv > PH_LAST) begin
            r.phase  = PH_IDLE;
            r.status = mms_pkg::ST_OK;
            done     = 1'b1;
          end else begin
            r.clr_stall = 1'b1;
            if (!exits(kv, sw)) begin
              r.phase = kv;
              done    = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  logic        dwell_nz;
  logic        endsw;
  leave_t      tl_start;
  leave_t      tl_tick;
  leave_t      tl_dwell;
  logic [20:0] el_sum;
  logic [19:0] el;
  logic [7:0]  sr_new;
  logic        to_hit;
  logic        push_back;

  assign dwell_nz = (cfg_i.dwell_ms != 16'd0);
  assign endsw    = item_i.end_switch;
  assign tl_start = toggle_leave(PH_RUN1, endsw, 1'b1, dwell_nz);
  assign tl_tick  = toggle_leave(state_i.phase, endsw, 1'b1, dwell_nz);
  assign tl_dwell = toggle_leave(state_i.phase - PH_DWELL, endsw, 1'b0, dwell_nz);

  assign el_sum = {1'b0, state_i.elapsed_ms} + {11'd0, cfg_i.tick_period_ms};
  assign el     = el_sum[20] ? '1 : el_sum[19:0];

  always_comb begin
    if (!item_i.stall_sense) begin
      sr_new = 8'd0;
    end else if (state_i.stall_run == 8'hFF) begin
      sr_new = state_i.stall_run;
    end else begin
      sr_new = state_i.stall_run + 8'd1;
    end
  end

  assign push_back = (state_i.run_mode == mms_pkg::MODE_PUSH) && (state_i.phase == PH_RUN2);

  always_comb begin
    if (push_back) begin
      to_hit = (el >= {4'd0, cfg_i.backup_cap_ms});
    end else if (state_i.run_mode == mms_pkg::MODE_TOGGLE) begin
      to_hit = (el > state_i.time_limit);
    end else begin
      to_hit = (el >= state_i.time_limit);
    end
  end

  always_comb begin
    state_o         = state_i;
    result_o.status = mms_pkg::ST_IDLE;
    if (item_i.action == mms_pkg::ACT_START) begin
      if (item_i.mode == mms_pkg::MODE_STOP) begin
        state_o.phase = PH_IDLE;
      end else begin
        state_o.run_mode        = item_i.mode;
        state_o.elapsed_ms      = '0;
        state_o.stall_run       = '0;
        state_o.dwell_left_ms   = '0;
        state_o.time_limit      = item_i.timeout_ms;
        state_o.stall_threshold = item_i.stall_limit;
        state_o.phase           = PH_RUN1;
        state_o.drive_reverse   = 1'b0;
        result_o.status         = mms_pkg::ST_RUN;
        case (item_i.mode)
          mms_pkg::MODE_SINGLE: begin
            state_o.drive_reverse = item_i.direction;
            if (endsw) begin
              state_o.phase   = PH_IDLE;
              result_o.status = mms_pkg::ST_OK;
            end
          end
          mms_pkg::MODE_PUSH: begin
            if (endsw) begin
              state_o.phase   = PH_IDLE;
              result_o.status = mms_pkg::ST_OK;
            end else if (item_i.front_switch) begin
              state_o.phase   = PH_IDLE;
              result_o.status = mms_pkg::ST_NOITEM;
            end
          end
          default: begin
            if (exits(PH_RUN1, endsw)) begin
              state_o.phase   = tl_start.phase;
              result_o.status = tl_start.status;
              if (tl_start.load_dwell) begin
                state_o.dwell_left_ms = cfg_i.dwell_ms;
              end
            end
          end
        endcase
      end
    end else if (state_i.phase == PH_IDLE) begin
      result_o.status = mms_pkg::ST_IDLE;
    end else if (state_i.phase >= PH_DWELL1) begin
      // Dwell: no time, stall or timeout counting.
      if (state_i.dwell_left_ms > {6'd0, cfg_i.tick_period_ms}) begin
        state_o.dwell_left_ms = state_i.dwell_left_ms - {6'd0, cfg_i.tick_period_ms};
        result_o.status       = mms_pkg::ST_RUN;
      end else begin
        state_o.dwell_left_ms = '0;
        state_o.phase         = tl_dwell.phase;
        result_o.status       = tl_dwell.status;
        if (tl_dwell.load_dwell) begin
          state_o.dwell_left_ms = cfg_i.dwell_ms;
        end
        if (tl_dwell.clr_stall) begin
          state_o.stall_run = '0;
        end
      end
    end else begin
      state_o.elapsed_ms = el;
      result_o.status    = mms_pkg::ST_RUN;
      if (to_hit) begin
        state_o.phase   = PH_IDLE;
        result_o.status = push_back ? mms_pkg::ST_OK : mms_pkg::ST_TIMEOUT;
      end else if ((state_i.run_mode == mms_pkg::MODE_PUSH) && (state_i.phase == PH_RUN1)
                   && item_i.front_switch) begin
        state_o.phase   = PH_IDLE;
        result_o.status = mms_pkg::ST_NOITEM;
      end else begin
        state_o.stall_run = sr_new;
        if (sr_new >= state_i.stall_threshold) begin
          state_o.phase   = PH_IDLE;
          result_o.status = mms_pkg::ST_STALL;
        end else if (state_i.run_mode == mms_pkg::MODE_PUSH) begin
          if ((state_i.phase != PH_RUN1) || endsw) begin
            if (state_i.phase == PH_RUN1) begin
              state_o.phase         = PH_RUN2;
              state_o.elapsed_ms    = '0;
              state_o.drive_reverse = 1'b1;
            end
            if (item_i.back_switch) begin
              state_o.phase   = PH_IDLE;
              result_o.status = mms_pkg::ST_OK;
            end
          end
        end else if (state_i.run_mode == mms_pkg::MODE_TOGGLE) begin
          if (exits(state_i.phase, endsw)) begin
            state_o.phase   = tl_tick.phase;
            result_o.status = tl_tick.status;
            if (tl_tick.load_dwell) begin
              state_o.dwell_left_ms = cfg_i.dwell_ms;
            end
            if (tl_tick.clr_stall) begin
              state_o.stall_run = '0;
            end
          end
        end else if (endsw) begin
          state_o.phase   = PH_IDLE;
          result_o.status = mms_pkg::ST_OK;
        end
      end
    end
    result_o.motor_on      = (state_o.phase != PH_IDLE);
    result_o.motor_reverse = state_o.drive_reverse;
  end

endmodule

// ===== src/motor_move_supervisor.sv =====
// Top level of the motor move supervisor: beat pipeline, state and registers.
//
// Use: the input channel carries start and tick beats (in_item_i), each
// answered by exactly one result beat on the output channel (out_item_o)
// that gives the move status and the motor enable and direction drives.
// Both channels move a beat at a rising edge where valid is high and stall
// is low. Configuration (tick period, push backup cap, toggle dwell) sits in
// an APB-style register file at byte addresses 0, 4 and 8; it must be
// written only while no beat is in flight, which the block does not enforce.
// Path: a beat accepted into the input register is evaluated by one short
// combinational step, and its result is registered in the result register,
// which drives out_valid_o.
// Throughput: one beat per cycle while the output is not stalled; the move
// state is updated as the beat passes from the input register to the result
// register, so back-to-back beats see each other's effects in order.
// Stall: while the result register holds an untaken beat, the input register
// still fills; only when both are full is in_stall_o raised.
// Reset: clears the move state to idle and both valid flags, and restores
// the register defaults (20 ms tick, 500 ms cap, 500 ms dwell).
`include "motor_move_supervisor_macros.svh"

module motor_move_supervisor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mms_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mms_pkg::out_item_t              out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mms_pkg::RegAddrW-1:0]    paddr,
  input  logic [mms_pkg::RegDataW-1:0]    pwdata,
  output logic [mms_pkg::RegDataW-1:0]    prdata,
  output logic                            pready
);

  mms_pkg::cfg_t      cfg;
  mms_pkg::state_t    state_q;
  mms_pkg::state_t    state_d;
  mms_pkg::in_item_t  in_item_q;
  logic               in_valid_q;
  mms_pkg::out_item_t out_item_q;
  mms_pkg::out_item_t out_item_d;
  logic               out_valid_q;
  logic               advance;
  logic               out_run;
  logic               out_end;

  mms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mms_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (out_item_d)
  );

  // The result register can take a new beat when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  // Move state commits exactly once per beat, when it enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance && in_valid_q) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A running status and a final status, as seen on a valid result beat.
  assign out_run = out_valid_o && (out_item_o.status == mms_pkg::ST_RUN);
  assign out_end = out_valid_o && ((out_item_o.status == mms_pkg::ST_OK) ||
                                   (out_item_o.status == mms_pkg::ST_TIMEOUT) ||
                                   (out_item_o.status == mms_pkg::ST_NOITEM) ||
                                   (out_item_o.status == mms_pkg::ST_STALL));

  `MMS_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `MMS_ASSERT_NXT(a_beat_reaches_output, clk_i, rst_ni, in_valid_q && advance, out_valid_o)
  `MMS_ASSERT_IMP(a_run_drives_motor, clk_i, rst_ni, out_run, out_item_o.motor_on)
  `MMS_ASSERT_IMP(a_end_stops_motor, clk_i, rst_ni, out_end, !out_item_o.motor_on)

endmodule
